### rtl/lkc_pkg.sv
`default_nettype none

package lkc_pkg;

	localparam int CAPACITY = 256;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FILL_W   = 9;
	localparam int LVL_N    = $clog2(CAPACITY);

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic cmp;
		logic active;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_UPD  = 2'b10
	} state_t;

endpackage

`default_nettype wire

### rtl/lkc_cell.sv
`default_nettype none

module lkc_cell import lkc_pkg::*; (
	input  wire            clk,
	input  wire cell_ctl_t ctl,
	input  wire key_t      probe,
	input  wire key_t      prev,
	output key_t           key,
	output logic           match
);

	key_t key_q;
	logic match_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			match_q <= ctl.active && (key_q == probe);
		end
		if (ctl.shift) begin
			key_q <= prev;
		end
	end

	assign key   = key_q;
	assign match = match_q;

endmodule

`default_nettype wire

### rtl/lkc_prefix.sv
`default_nettype none

module lkc_prefix import lkc_pkg::*; (
	input  wire  [CAPACITY-1:0] m,
	output logic [CAPACITY-1:0] earlier
);

	// exclusive prefix OR: earlier[i] = |m[i-1:0]
	logic [CAPACITY-1:0] lvl [0:LVL_N];

	assign lvl[0] = {m[CAPACITY-2:0], 1'b0};

	for (genvar k = 0; k < LVL_N; k++) begin : g_lvl
		for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
			if (i >= (1 << k)) begin : g_or
				assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
			end else begin : g_pass
				assign lvl[k+1][i] = lvl[k][i];
			end
		end
	end

	assign earlier = lvl[LVL_N];

endmodule

`default_nettype wire

### rtl/lru_key_cache_tag_store.sv
// channel  | handshake         | fields
// ---------+-------------------+---------------------------------------------
// in       | start, busy       | key_code
// out      | done (strobe)     | hit, evicted_valid, evicted_key, fill_count
//
// No new key is accepted while busy: the accept edge registers every cell's
// compare, the next cycle resolves the first match through a prefix-OR tree
// and shifts the cell chain. busy is high during that update cycle; the
// result strobe follows in the next cycle. Reset empties the store (count to
// zero); cell contents are not cleared. The receiver cannot stall the result.
`default_nettype none

module lru_key_cache_tag_store import lkc_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [KEY_W-1:0]  key_code,
	output logic              done,
	output logic              hit,
	output logic              evicted_valid,
	output logic [KEY_W-1:0]  evicted_key,
	output logic [FILL_W-1:0] fill_count
);

	state_t              state_q;
	cnt_t                count_q;
	key_t                key_s1;
	logic                accept;
	logic                upd;
	key_t                keys    [0:CAPACITY-1];
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] earlier;
	logic                any_hit;
	logic                full;
	cnt_t                count_nxt;

	assign busy   = (state_q == ST_UPD);
	assign accept = start && !busy;
	assign upd    = busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= key_code;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		key_t      prev;

		assign ctl.cmp    = accept;
		assign ctl.active = (count_q > CNT_W'(i));
		assign ctl.shift  = upd && !earlier[i];

		if (i == 0) begin : g_head
			assign prev = key_s1;
		end else begin : g_link
			assign prev = keys[i-1];
		end

		lkc_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.probe (key_code),
			.prev  (prev),
			.key   (keys[i]),
			.match (match_vec[i])
		);
	end

	lkc_prefix u_prefix (
		.m       (match_vec),
		.earlier (earlier)
	);

	assign any_hit   = |match_vec;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign count_nxt = (any_hit || full) ? count_q : count_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= upd;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					count_q <= count_nxt;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			hit           <= any_hit;
			evicted_valid <= !any_hit && full;
			evicted_key   <= (!any_hit && full) ? keys[CAPACITY-1] : '0;
			fill_count    <= FILL_W'(count_nxt);
		end
	end

`ifndef SYNTHESIS
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without update cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted_valid |-> !hit && (fill_count == FILL_W'(CAPACITY)))
		else $error("eviction without full miss");

	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $onehot0(match_vec))
		else $error("duplicate key in store");
`endif

endmodule

`default_nettype wire
